[hw/rtl/vsc_pkg.sv]
// Shared types and constants for the Vigenere stream cipher.
package vsc_pkg;

   // Command codes carried in the low bits of req_tuser
   localparam logic [1:0] CMD_WR_ALPHA = 2'd0;
   localparam logic [1:0] CMD_WR_KEY   = 2'd1;
   localparam logic [1:0] CMD_PROCESS  = 2'd2;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_ALPHA_LEN = 2'd0;
   localparam logic [1:0] REG_KEY_LEN   = 2'd1;
   localparam logic [1:0] REG_DECRYPT   = 2'd2;

   localparam int LEN_W       = 7;
   localparam int CHAR_W      = 8;
   localparam int IDX_W       = 6;
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 8;
   localparam int RSP_USER_W  = 1;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [LEN_W-1:0] ALPHA_LEN_RESET = 7'd52;
   localparam logic [LEN_W-1:0] KEY_LEN_RESET   = 7'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_INDEX,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0] alphabet_length;
      logic [LEN_W-1:0] key_length;
      logic             decrypt_mode;
   } cfg_type;

   typedef struct packed {
      logic wr_alpha;
      logic wr_key;
      logic start;
      logic match;
      logic index;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

[hw/rtl/vsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/vsc_ctrl.sv]
// Sequencer for the cipher: decodes commands and steps each character through.
module vsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            command,
   input  vsc_pkg::dp_status_type status,
   output logic                  req_ready,
   output vsc_pkg::dp_cmd_type   cmd
);
   import vsc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (command)
                  CMD_WR_ALPHA: cmd.wr_alpha = 1'b1;
                  CMD_WR_KEY:   cmd.wr_key   = 1'b1;
                  CMD_PROCESS: begin
                     cmd.start = 1'b1;
                     state_in  = ST_MATCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_INDEX;
         end
         ST_INDEX: begin
            cmd.index = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            // hold until the result register can take a word
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[hw/rtl/vsc_datapath.sv]
// Tables, match logic, index arithmetic and result register of the cipher.
module vsc_datapath #(
   parameter int ALPHABET_DEPTH = 64,
   parameter int KEY_DEPTH      = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vsc_pkg::cfg_type                    cfg,
   input  vsc_pkg::dp_cmd_type                 cmd,
   output vsc_pkg::dp_status_type              status,
   input  logic [vsc_pkg::IDX_W-1:0]           table_index,
   input  logic [vsc_pkg::CHAR_W-1:0]          char_value,
   input  logic                                first_of_message,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [vsc_pkg::CHAR_W-1:0]          char_out,
   output logic                                passed_through
);
   import vsc_pkg::*;

   localparam int AIW = $clog2(ALPHABET_DEPTH);
   localparam int SW  = AIW + 1;
   localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int PW  = KAW + 1;

   // alphabet held in flops for the parallel compare, mirrored in a RAM for
   // the indexed read of the result
   logic [CHAR_W-1:0]         alpha_ff [ALPHABET_DEPTH];
   logic [CHAR_W-1:0]         text_ff;
   logic [KAW-1:0]            key_pos_ff;
   logic [KAW-1:0]            key_pos_in;
   logic [KAW-1:0]            pos_sel;
   logic [ALPHABET_DEPTH-1:0] text_hit_ff;
   logic [ALPHABET_DEPTH-1:0] key_hit_ff;
   logic                      text_miss_ff;
   logic                      key_miss_ff;
   logic                      rsp_valid_ff;
   logic [CHAR_W-1:0]         rsp_char_ff;
   logic                      rsp_pass_ff;

   logic [CHAR_W-1:0] key_rd_data;
   logic [CHAR_W-1:0] alpha_rd_data;
   logic              alpha_wr_ok;
   logic              key_wr_ok;
   logic [SW-1:0]     alen;
   logic [PW-1:0]     klen;
   logic [PW-1:0]     pos_next;
   logic [AIW-1:0]    text_idx;
   logic [AIW-1:0]    key_idx;
   logic              text_found;
   logic              key_found;
   logic [SW-1:0]     sum;
   logic [SW-1:0]     res_idx;

   assign alpha_wr_ok = cmd.wr_alpha && (int'(table_index) < ALPHABET_DEPTH);
   assign key_wr_ok   = cmd.wr_key && (int'(table_index) < KEY_DEPTH);

   // saturate the configured lengths to the table depths, a zero key length to one
   always_comb begin
      if (int'(cfg.alphabet_length) > ALPHABET_DEPTH) begin
         alen = SW'(ALPHABET_DEPTH);
      end else begin
         alen = SW'(cfg.alphabet_length);
      end
      if (int'(cfg.key_length) > KEY_DEPTH) begin
         klen = PW'(KEY_DEPTH);
      end else if (cfg.key_length == '0) begin
         klen = PW'(1);
      end else begin
         klen = PW'(cfg.key_length);
      end
   end

   // restart the key on a new message or after the key length shrank
   always_comb begin
      if (first_of_message || (PW'(key_pos_ff) >= klen)) begin
         pos_sel = '0;
      end else begin
         pos_sel = key_pos_ff;
      end
      pos_next = PW'(pos_sel) + PW'(1);
      if (pos_next >= klen) begin
         key_pos_in = '0;
      end else begin
         key_pos_in = pos_next[KAW-1:0];
      end
   end

   // first hit wins
   always_comb begin
      text_idx   = '0;
      key_idx    = '0;
      text_found = |text_hit_ff;
      key_found  = |key_hit_ff;
      for (int i = ALPHABET_DEPTH - 1; i >= 0; i--) begin
         if (text_hit_ff[i]) begin
            text_idx = AIW'(i);
         end
         if (key_hit_ff[i]) begin
            key_idx = AIW'(i);
         end
      end
   end

   always_comb begin
      sum = '0;
      if (cfg.decrypt_mode) begin
         if (text_idx >= key_idx) begin
            res_idx = SW'(text_idx) - SW'(key_idx);
         end else begin
            res_idx = SW'(text_idx) + alen - SW'(key_idx);
         end
      end else begin
         sum = SW'(text_idx) + SW'(key_idx);
         if (sum >= alen) begin
            res_idx = sum - alen;
         end else begin
            res_idx = sum;
         end
      end
   end

   vsc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_ok),
      .wr_addr (KAW'(table_index)),
      .wr_data (char_value),
      .rd_en   (cmd.start),
      .rd_addr (pos_sel),
      .rd_data (key_rd_data)
   );

   vsc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (ALPHABET_DEPTH)
   ) u_alpha_ram (
      .clock   (clock),
      .wr_en   (alpha_wr_ok),
      .wr_addr (AIW'(table_index)),
      .wr_data (char_value),
      .rd_en   (cmd.index),
      .rd_addr (res_idx[AIW-1:0]),
      .rd_data (alpha_rd_data)
   );

   always_ff @(posedge clock) begin
      if (alpha_wr_ok) begin
         alpha_ff[AIW'(table_index)] <= char_value;
      end
      if (cmd.start) begin
         text_ff <= char_value;
      end
      if (cmd.match) begin
         for (int i = 0; i < ALPHABET_DEPTH; i++) begin
            text_hit_ff[i] <= (alpha_ff[i] == text_ff) && (int'(alen) > i);
            key_hit_ff[i]  <= (alpha_ff[i] == key_rd_data) && (int'(alen) > i);
         end
      end
      if (cmd.index) begin
         text_miss_ff <= !text_found;
         key_miss_ff  <= !key_found;
      end
      if (cmd.load) begin
         if (text_miss_ff) begin
            rsp_char_ff <= text_ff;
            rsp_pass_ff <= 1'b1;
         end else begin
            rsp_char_ff <= alpha_rd_data;
            rsp_pass_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            key_pos_ff <= key_pos_in;
         end
         // drop the result when the key byte is not in the alphabet but the text is
         if (cmd.load && (text_miss_ff || !key_miss_ff)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign char_out        = rsp_char_ff;
   assign passed_through  = rsp_pass_ff;

endmodule

[hw/rtl/vigenere_stream_cipher.sv]
// A table write word is taken while the sequencer is idle. A character word shows its
// result on rsp_tvalid after the key RAM read, the compare against the alphabet, the
// index add or subtract with the alphabet RAM read, and the result register load.
// Throughput: one table write per cycle while idle; a new character is taken once the
// last is loaded, and the result register holds that word while the next is taken.
// Reset: synchronous, clears the sequencer, key position and result valid and
// loads the length and mode registers; alphabet and key tables are undefined.
module vigenere_stream_cipher #(
   parameter int ALPHABET_DEPTH = 64,
   parameter int KEY_DEPTH      = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [5:0] table_index, [13:6] char_value, [15:14] zero
   input  logic [vsc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] command, [2] first_of_message
   input  logic [vsc_pkg::REQ_USER_W-1:0]     req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] char_out
   output logic [vsc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] passed_through
   output logic [vsc_pkg::RSP_USER_W-1:0]     rsp_tuser,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vsc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [vsc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [vsc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import vsc_pkg::*;

   logic [LEN_W-1:0] alpha_len_ff;
   logic [LEN_W-1:0] key_len_ff;
   logic             decrypt_ff;
   logic             csr_wr;
   logic [1:0]       csr_reg;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   logic       req_ready_int;
   logic [1:0] command;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // registers sit on 4-byte steps
   assign csr_reg    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_len_ff <= ALPHA_LEN_RESET;
         key_len_ff   <= KEY_LEN_RESET;
         decrypt_ff   <= 1'b0;
      end else if (csr_wr) begin
         case (csr_reg)
            REG_ALPHA_LEN: alpha_len_ff <= csr_pwdata[LEN_W-1:0];
            REG_KEY_LEN:   key_len_ff   <= csr_pwdata[LEN_W-1:0];
            REG_DECRYPT:   decrypt_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_ALPHA_LEN: csr_prdata = CSR_DATA_W'(alpha_len_ff);
         REG_KEY_LEN:   csr_prdata = CSR_DATA_W'(key_len_ff);
         REG_DECRYPT:   csr_prdata = CSR_DATA_W'(decrypt_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.alphabet_length = alpha_len_ff;
   assign cfg.key_length      = key_len_ff;
   assign cfg.decrypt_mode    = decrypt_ff;

   assign command    = req_tuser[1:0];
   assign req_tready = req_ready_int;

   // sequencer: table writes finish in the idle state, characters walk
   // through match, index and read
   vsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .command   (command),
      .status    (status),
      .req_ready (req_ready_int),
      .cmd       (cmd)
   );

   vsc_datapath #(
      .ALPHABET_DEPTH (ALPHABET_DEPTH),
      .KEY_DEPTH      (KEY_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .table_index      (req_tdata[5:0]),
      .char_value       (req_tdata[13:6]),
      .first_of_message (req_tuser[2]),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .char_out         (rsp_tdata),
      .passed_through   (rsp_tuser[0])
   );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking stream testbench for the Vigenere cipher: directed rows, then random phases.
module tb;
   import vsc_pkg::*;

   // Command three is undefined; the block must drop it without a trace
   localparam logic [1:0] CMD_NONE   = 2'd3;
   // Register slot with nothing behind it
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam int TABLE_DEPTH   = 64;
   localparam int CYCLE_LIMIT   = 500000;
   // Cycles to let a result-free character word clear the pipeline
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_WORDS   = 68;
   localparam int FIXED_PHASES  = 9;
   localparam int RANDOM_PHASES = 3;
   localparam int DIRECTED_ROWS = 20;

   // One result word: ciphered or copied byte plus the pass-through flag
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              pass;
   } cipher_word_type;

   // One directed row; exp_* are used only where typed is set
   typedef struct packed {
      logic [1:0]        cmd;
      logic [IDX_W-1:0]  idx;
      logic [CHAR_W-1:0] ch;
      logic              first;
      logic              typed;
      logic [CHAR_W-1:0] exp_ch;
      logic              exp_pass;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [5:0] table_index, [13:6] char_value, [15:14] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [1:0] command, [2] first_of_message
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [7:0] char_out
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [0] passed_through
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow state of the cipher
   logic [CHAR_W-1:0] alpha_copy [TABLE_DEPTH];
   logic [CHAR_W-1:0] key_copy   [TABLE_DEPTH];
   int                key_cursor = 0;
   logic [LEN_W-1:0]  alpha_len_cfg = ALPHA_LEN_RESET;
   logic [LEN_W-1:0]  key_len_cfg   = KEY_LEN_RESET;
   logic              decrypt_cfg   = 1'b0;

   // Result words still owed by the block, oldest first
   cipher_word_type pending_chars [$];
   cipher_word_type oldest_char;
   int              error_count = 0;
   int              cycle_count = 0;
   int              burst_left  = 0;
   int unsigned     stall_tick  = 0;

   // Directed rows run right after the table preload, with reset registers
   // (52 letters A-Z a-z in use, key length one, encrypt)
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_PROCESS,  6'd0,  "A",   1'b1, 1'b1, "A",   1'b0},  // zero plus zero
      '{CMD_PROCESS,  6'd63, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1},  // in table but past length
      '{CMD_PROCESS,  6'd0,  8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
      '{CMD_PROCESS,  6'd17, "z",   1'b0, 1'b1, "z",   1'b0},  // top index, key zero
      '{CMD_WR_KEY,   6'd0,  "B",   1'b0, 1'b0, 8'h00, 1'b0},
      '{CMD_PROCESS,  6'd42, "z",   1'b1, 1'b1, "A",   1'b0},  // sum wraps to zero
      '{CMD_PROCESS,  6'd0,  "Y",   1'b0, 1'b1, "Z",   1'b0},
      '{CMD_WR_KEY,   6'd63, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{CMD_WR_ALPHA, 6'd63, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{CMD_WR_KEY,   6'd0,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},  // key byte outside alphabet
      '{CMD_PROCESS,  6'd5,  "C",   1'b1, 1'b0, 8'h00, 1'b0},  // so no word comes back
      '{CMD_PROCESS,  6'd0,  8'h80, 1'b0, 1'b1, 8'h80, 1'b1},  // copy still wins
      '{CMD_NONE,     6'd63, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{CMD_WR_KEY,   6'd0,  "c",   1'b0, 1'b0, 8'h00, 1'b0},
      '{CMD_PROCESS,  6'd0,  "x",   1'b0, 1'b0, 8'h00, 1'b0},
      '{CMD_WR_ALPHA, 6'd5,  "!",   1'b0, 1'b0, 8'h00, 1'b0},  // F leaves the alphabet
      '{CMD_PROCESS,  6'd0,  "F",   1'b0, 1'b1, "F",   1'b1},
      '{CMD_PROCESS,  6'd0,  "!",   1'b0, 1'b0, 8'h00, 1'b0},
      '{CMD_WR_ALPHA, 6'd5,  "F",   1'b0, 1'b0, 8'h00, 1'b0},
      '{CMD_PROCESS,  6'd0,  8'h7F, 1'b1, 1'b1, 8'h7F, 1'b1}
   };

   // Register settings per phase: extremes, saturation, zero lengths, both modes
   int phase_alpha_len [FIXED_PHASES] = '{64, 64, 1, 1, 0, 127, 26, 26, 2};
   int phase_key_len   [FIXED_PHASES] = '{64, 64, 1, 1, 0, 127, 5, 5, 3};
   int phase_decrypt   [FIXED_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 1};

   vigenere_stream_cipher DUT (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Free-running cycle count; kill a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: rotate through always ready, light stall, heavy stall and a one-in-four strobe
   always @(negedge clock) begin
      case (stall_tick[8:7])
         2'd0: rsp_tready = 1'b1;
         2'd1: rsp_tready = ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready = ($urandom_range(0, 9) == 0);
         default: rsp_tready = (stall_tick[1:0] == 2'd0);
      endcase
      stall_tick++;
   end

   // Result checker: compare each accepted word with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected word: char_out %h passed_through %b",
                   rsp_tdata, rsp_tuser[0]);
            error_count++;
         end else begin
            oldest_char = pending_chars.pop_front();
            if (rsp_tdata !== oldest_char.ch) begin
               $error("char_out: expected %h, got %h", oldest_char.ch, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== oldest_char.pass) begin
               $error("passed_through: expected %b, got %b", oldest_char.pass,
                      rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // Preload byte: upper case, lower case, digits, then 0xFF and 0x00
   function automatic logic [CHAR_W-1:0] preload_char(input int slot);
      if (slot < 26) return CHAR_W'(8'h41 + slot);
      if (slot < 52) return CHAR_W'(8'h61 + slot - 26);
      if (slot < 62) return CHAR_W'(8'h30 + slot - 52);
      if (slot == 62) return 8'hFF;
      return 8'h00;
   endfunction

   function automatic int used_alpha_len();
      return (alpha_len_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(alpha_len_cfg);
   endfunction

   function automatic int used_key_len();
      if (key_len_cfg > TABLE_DEPTH) return TABLE_DEPTH;
      return (key_len_cfg == 0) ? 1 : int'(key_len_cfg);
   endfunction

   // First slot among the active entries holding the byte, -1 if none
   function automatic int alphabet_slot(input logic [CHAR_W-1:0] ch, input int len);
      for (int i = 0; i < len; i++)
         if (alpha_copy[i] == ch) return i;
      return -1;
   endfunction

   // Apply one accepted word to the shadow state and work out its result
   function automatic void cipher_predict(input logic [1:0] cmd,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic first,
                                          output bit has_word,
                                          output cipher_word_type word);
      int alen;
      int klen;
      int pos;
      int text_slot;
      int key_slot;
      int sum;
      has_word = 1'b0;
      word = '0;
      case (cmd)
         CMD_WR_ALPHA: alpha_copy[idx] = ch;
         CMD_WR_KEY: key_copy[idx] = ch;
         CMD_PROCESS: begin
            alen = used_alpha_len();
            klen = used_key_len();
            // restart the key on a new message or after the key was shortened
            pos = (first || key_cursor >= klen) ? 0 : key_cursor;
            key_cursor = (pos + 1 >= klen) ? 0 : pos + 1;
            text_slot = alphabet_slot(ch, alen);
            if (text_slot < 0) begin
               has_word = 1'b1;
               word = '{ch, 1'b1};
            end else begin
               key_slot = alphabet_slot(key_copy[pos], alen);
               if (key_slot >= 0) begin
                  if (decrypt_cfg) begin
                     sum = text_slot - key_slot;
                     if (sum < 0) sum += alen;
                  end else begin
                     sum = text_slot + key_slot;
                     if (sum >= alen) sum -= alen;
                  end
                  has_word = 1'b1;
                  word = '{alpha_copy[sum], 1'b0};
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Offer one request word; called and returns at a falling edge.
   // Valid stays high across a burst; a gap opens when the burst runs out.
   task automatic send_word(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [CHAR_W-1:0] ch, input logic first,
                            input logic typed, input cipher_word_type typed_word);
      bit              has_word;
      cipher_word_type word;
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_tdata = {2'b00, ch, idx};
      req_tuser = {first, cmd};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      cipher_predict(cmd, idx, ch, first, has_word, word);
      // a typed row overrides the prediction
      if (typed) pending_chars.push_back(typed_word);
      else if (has_word) pending_chars.push_back(word);
      burst_left--;
      @(negedge clock);
   endtask

   // Two-phase register write; random junk above the field width
   task automatic csr_write(input logic [1:0] reg_sel, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] field_mask;
      field_mask = (reg_sel == REG_DECRYPT) ? 32'h1 : 32'h7F;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'({reg_sel, 2'b00});
      csr_pwdata = ($urandom() & ~field_mask) | (value & field_mask);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (reg_sel)
         REG_ALPHA_LEN: alpha_len_cfg = csr_pwdata[LEN_W-1:0];
         REG_KEY_LEN: key_len_cfg = csr_pwdata[LEN_W-1:0];
         REG_DECRYPT: decrypt_cfg = csr_pwdata[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Hold the sender until every owed word is back, then let the pipe settle
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly message text drawn from the live alphabet, some key edits,
   // rare alphabet edits, stray bytes and undefined commands as noise
   task automatic random_words(input int count);
      int                done;
      int                roll;
      int                alen;
      int                klen;
      logic [IDX_W-1:0]  idx;
      logic [CHAR_W-1:0] ch;
      logic              first;
      done = 0;
      while (done < count) begin
         alen = used_alpha_len();
         klen = used_key_len();
         roll = $urandom_range(0, 99);
         idx = IDX_W'($urandom());
         ch = CHAR_W'($urandom());
         first = ($urandom_range(0, 9) == 0);
         if (roll < 6) begin
            send_word(CMD_WR_ALPHA, idx, ch, first, 1'b0, '0);
            done++;
         end else if (roll < 16) begin
            if ($urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, klen - 1));
            if (alen > 0 && $urandom_range(0, 6) != 0)
               ch = alpha_copy[$urandom_range(0, alen - 1)];
            send_word(CMD_WR_KEY, idx, ch, first, 1'b0, '0);
            done++;
         end else if (roll < 19) begin
            // ignored by the block, so not counted
            send_word(CMD_NONE, idx, ch, first, 1'b0, '0);
         end else begin
            if (alen > 0 && $urandom_range(0, 4) != 0)
               ch = alpha_copy[$urandom_range(0, alen - 1)];
            send_word(CMD_PROCESS, idx, ch, first, 1'b0, '0);
            done++;
         end
      end
   endtask

   // Reprogram all three registers while idle, then run a random phase
   task automatic run_phase(input int alen, input int klen, input int decrypt);
      drain_results();
      csr_write(REG_ALPHA_LEN, alen);
      csr_write(REG_KEY_LEN, klen);
      csr_write(REG_DECRYPT, decrypt);
      random_words(PHASE_WORDS);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Fill both tables so no active entry is ever read unwritten
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_word(CMD_WR_ALPHA, IDX_W'(i), preload_char(i), 1'b0, 1'b0, '0);
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_word(CMD_WR_KEY, IDX_W'(i), preload_char(i % 26), 1'b0, 1'b0, '0);

      foreach (directed_rows[r])
         send_word(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].ch,
                   directed_rows[r].first, directed_rows[r].typed,
                   '{directed_rows[r].exp_ch, directed_rows[r].exp_pass});

      for (int p = 0; p < FIXED_PHASES; p++) begin
         run_phase(phase_alpha_len[p], phase_key_len[p], phase_decrypt[p]);
         // poke the empty register slot once while idle; nothing may change
         if (p == 2) begin
            drain_results();
            csr_write(REG_UNUSED, $urandom());
         end
      end
      for (int p = 0; p < RANDOM_PHASES; p++)
         run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 1));

      drain_results();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/vsc_pkg.sv
hw/rtl/vsc_ram.sv
hw/rtl/vsc_ctrl.sv
hw/rtl/vsc_datapath.sv
hw/rtl/vigenere_stream_cipher.sv
dv/tb.sv
